/* src/serial_key_injection_parser_defines.svh */
// Assertion macros shared by the parser RTL.
`ifndef SERIAL_KEY_INJECTION_PARSER_DEFINES_SVH
`define SERIAL_KEY_INJECTION_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising edge outside reset.
`define SKIP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define SKIP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `SKIP_ASSERT(lbl, clk, rstn, !(cond))

`else

`define SKIP_ASSERT(lbl, clk, rstn, prop)
`define SKIP_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* src/skip_pkg.sv */
package skip_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_A      = 8'h55;
  localparam logic [7:0] SYNC_B      = 8'hAA;
  localparam logic [7:0] KA_ZERO     = 8'h00;
  localparam logic [7:0] KEY_SHORT   = 8'h03;
  localparam logic [7:0] KEY_LONG    = 8'h04;
  localparam logic [7:0] KA_FEATURE  = 8'h05;

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_IDX_INVALID_KEY = 3'd0;
  localparam logic [2:0] CFG_IDX_BLOCKED_KEY = 3'd1;
  localparam logic [2:0] CFG_IDX_SHORT_HOLD  = 3'd2;
  localparam logic [2:0] CFG_IDX_LONG_HOLD   = 3'd3;
  localparam logic [2:0] CFG_IDX_FEAT_EN     = 3'd4;

  // Configuration reset values
  localparam logic [7:0] RST_INVALID_KEY = 8'd19;
  localparam logic [7:0] RST_BLOCKED_KEY = 8'd16;
  localparam logic [5:0] RST_SHORT_HOLD  = 6'd5;
  localparam logic [5:0] RST_LONG_HOLD   = 6'd45;
  localparam logic       RST_FEAT_EN     = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } skip_in_t;

  typedef struct packed {
    logic       connected;
    logic       key_valid;
    logic [7:0] key_code;
    logic [7:0] viewer_features;
  } skip_out_t;

  typedef struct packed {
    logic [7:0] invalid_key_code;
    logic [7:0] blocked_key_code;
    logic [5:0] short_hold_polls;
    logic [5:0] long_hold_polls;
    logic       feature_packets_enable;
  } skip_cfg_t;

  // Packet events from the framer
  typedef struct packed {
    logic done;      // packet completed
    logic key_load;  // key code byte of a key packet
    logic key_long;  // long press packet
  } skip_evt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KA1,
    ST_KA2,
    ST_KA3,
    ST_KAFEAT,
    ST_KEY1,
    ST_KEY2,
    ST_KEY3S,
    ST_KEY3L
  } skip_state_t;

endpackage

/* src/skip_framer.sv */
`include "serial_key_injection_parser_defines.svh"

module skip_framer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_vld,
  input  logic [7:0]           rx_byte,
  input  logic                 feat_en,
  output skip_pkg::skip_evt_t  evt,
  output logic [7:0]           features
);
  import skip_pkg::*;

  skip_state_t state_r, state_nxt;
  logic [7:0]  feat_r, feat_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (byte_vld) begin
      case (state_r)
        ST_IDLE: begin
          if (rx_byte == SYNC_A)      state_nxt = ST_KA1;
          else if (rx_byte == SYNC_B) state_nxt = ST_KEY1;
        end
        ST_KA1:  state_nxt = (rx_byte == SYNC_B) ? ST_KA2 : ST_IDLE;
        ST_KA2: begin
          if (rx_byte == KA_ZERO)                    state_nxt = ST_KA3;
          else if (rx_byte == KA_FEATURE && feat_en) state_nxt = ST_KAFEAT;
          else                                       state_nxt = ST_IDLE;
        end
        ST_KEY1: state_nxt = (rx_byte == SYNC_A) ? ST_KEY2 : ST_IDLE;
        ST_KEY2: begin
          if (rx_byte == KEY_SHORT)     state_nxt = ST_KEY3S;
          else if (rx_byte == KEY_LONG) state_nxt = ST_KEY3L;
          else                          state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    evt      = '0;
    feat_nxt = feat_r;
    if (byte_vld) begin
      case (state_r)
        ST_KA3: begin
          if (rx_byte == KA_ZERO) begin
            evt.done = 1'b1;
            feat_nxt = '0;
          end
        end
        ST_KAFEAT: begin
          evt.done = 1'b1;
          feat_nxt = rx_byte;
        end
        ST_KEY3S: begin
          evt.done     = 1'b1;
          evt.key_load = 1'b1;
        end
        ST_KEY3L: begin
          evt.done     = 1'b1;
          evt.key_load = 1'b1;
          evt.key_long = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign features = feat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      feat_r  <= '0;
    end else begin
      state_r <= state_nxt;
      feat_r  <= feat_nxt;
    end
  end

  `SKIP_ASSERT(a_load_is_done, clk, rst_n, evt.key_load |-> evt.done)
  `SKIP_ASSERT(a_done_to_idle, clk, rst_n, evt.done |=> state_r == ST_IDLE)

endmodule

/* src/skip_inject.sv */
module skip_inject (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 is_poll,
  input  logic [7:0]           rx_byte,
  input  skip_pkg::skip_evt_t  evt,
  input  skip_pkg::skip_cfg_t  cfg,
  output logic                 key_valid,
  output logic [7:0]           key_code
);
  import skip_pkg::*;

  logic [7:0] pending_r, pending_nxt;
  logic [5:0] hold_r, hold_nxt;
  logic       long_r, long_nxt;
  logic [5:0] limit;
  logic [6:0] cnt_inc;

  assign limit   = long_r ? cfg.long_hold_polls : cfg.short_hold_polls;
  assign cnt_inc = {1'b0, hold_r} + 7'd1;

  always_comb begin
    pending_nxt = pending_r;
    hold_nxt    = hold_r;
    long_nxt    = long_r;
    key_valid   = 1'b0;
    key_code    = cfg.invalid_key_code;
    if (step) begin
      if (is_poll) begin
        if (pending_r != cfg.invalid_key_code) begin
          key_valid = 1'b1;
          key_code  = pending_r;
          if (cnt_inc >= {1'b0, limit}) begin
            pending_nxt = cfg.invalid_key_code;
            hold_nxt    = '0;
            long_nxt    = 1'b0;
          end else begin
            hold_nxt = cnt_inc[5:0];
          end
        end
      end else if (evt.key_load && rx_byte < cfg.invalid_key_code &&
                   rx_byte != cfg.blocked_key_code) begin
        pending_nxt = rx_byte;
        hold_nxt    = '0;
        long_nxt    = evt.key_long;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= RST_INVALID_KEY;
      hold_r    <= '0;
      long_r    <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      hold_r    <= hold_nxt;
      long_r    <= long_nxt;
    end
  end

endmodule

/* src/serial_key_injection_parser.sv */
// Serial key injection parser. Each request is either a received serial byte
// or a keyboard poll tick, and each gives exactly one result. Bytes run
// through a framer that knows keep-alive (55 AA 00 00, or 55 AA 05 <features>
// when feature packets are on) and key packets (AA 55, 03 short / 04 long,
// key code); a finished packet sets connected, and an acceptable key code
// becomes the injected key. Polls report that key until it has been held for
// short_hold_polls or long_hold_polls polls. One request per clock is sustained
// while out_ready stays high; a taken request goes into the input register,
// then the parse/hold logic writes its result into the result register
// once that register is empty or its result is being taken. While a
// result waits on out_ready the input register still takes one more request,
// then in_ready stays low until the waiting result is taken. Write the
// cfg_ registers only while no request is in flight.
`include "serial_key_injection_parser_defines.svh"

module serial_key_injection_parser (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  skip_pkg::skip_in_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output skip_pkg::skip_out_t out_data,
  // configuration writes
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import skip_pkg::*;

  skip_cfg_t cfg_r;

  skip_in_t  in_r;
  logic      in_vld_r, in_vld_nxt;
  skip_out_t out_r;
  logic      out_vld_r, out_vld_nxt;

  logic      proc;      // item in the input register moves to the result register
  logic      in_fire;
  logic      byte_vld;
  skip_evt_t evt;
  logic [7:0] features;
  logic      kv;
  logic [7:0] kc;
  skip_out_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invalid_key_code       <= RST_INVALID_KEY;
      cfg_r.blocked_key_code       <= RST_BLOCKED_KEY;
      cfg_r.short_hold_polls       <= RST_SHORT_HOLD;
      cfg_r.long_hold_polls        <= RST_LONG_HOLD;
      cfg_r.feature_packets_enable <= RST_FEAT_EN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_INVALID_KEY: cfg_r.invalid_key_code       <= cfg_wdata;
        CFG_IDX_BLOCKED_KEY: cfg_r.blocked_key_code       <= cfg_wdata;
        CFG_IDX_SHORT_HOLD:  cfg_r.short_hold_polls       <= cfg_wdata[5:0];
        CFG_IDX_LONG_HOLD:   cfg_r.long_hold_polls        <= cfg_wdata[5:0];
        CFG_IDX_FEAT_EN:     cfg_r.feature_packets_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register drains into the result register whenever
  // the result register is empty or its result is being taken this cycle.
  assign proc     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc;
  assign in_fire  = in_valid && in_ready;

  assign in_vld_nxt  = in_fire ? 1'b1 : (proc ? 1'b0 : in_vld_r);
  assign out_vld_nxt = proc ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  // Parse state only moves on bytes; hold state only on the moving item.
  assign byte_vld = proc && (in_r.req_type == REQ_BYTE);

  skip_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .rx_byte  (in_r.rx_byte),
    .feat_en  (cfg_r.feature_packets_enable),
    .evt      (evt),
    .features (features)
  );

  skip_inject u_inject (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc),
    .is_poll   (in_r.req_type == REQ_POLL),
    .rx_byte   (in_r.rx_byte),
    .evt       (evt),
    .cfg       (cfg_r),
    .key_valid (kv),
    .key_code  (kc)
  );

  always_comb begin
    res.connected       = evt.done;
    res.key_valid       = kv;
    res.key_code        = kc;
    res.viewer_features = features;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (proc) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `SKIP_ASSERT(a_empty_takes, clk, rst_n, !in_vld_r |-> in_ready)
  `SKIP_ASSERT(a_held_item_kept, clk, rst_n, (in_vld_r && !proc) |=> in_vld_r)
  `SKIP_ASSERT_NEVER(a_conn_and_key, clk, rst_n,
                     out_vld_r && out_r.connected && out_r.key_valid)

endmodule

/* tb/tb_top.sv */
module tb_top;
  import skip_pkg::*;

  // Clock, reset and DUT pins. Every input starts at a known value.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  skip_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  skip_out_t out_data;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_index = CFG_IDX_INVALID_KEY;
  logic [7:0] cfg_wdata = 8'h00;

  // When set, neither side inserts bubbles or stalls.
  bit calm = 1'b0;

  // Requests taken so far; the random phases count against this.
  int reqs_sent = 0;
  int mismatches = 0;

  always #1 clk = ~clk;

  serial_key_injection_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Parser mirror: register copies plus the framer / key-hold state.
  // ---------------------------------------------------------------------------
  logic [7:0]  inv_key_cfg;
  logic [7:0]  blk_key_cfg;
  logic [5:0]  short_cfg;
  logic [5:0]  long_cfg;
  logic        feat_en_cfg;

  skip_state_t frame_st;
  logic [7:0]  held_key;     // injected key; "none" when equal to inv_key_cfg
  logic [5:0]  hold_cnt;     // polls already reported for the held key
  logic        held_long;
  logic [7:0]  feat_reg;     // last viewer feature byte

  skip_out_t   due_results[$];  // oldest first

  task automatic mirror_reset();
    inv_key_cfg = RST_INVALID_KEY;
    blk_key_cfg = RST_BLOCKED_KEY;
    short_cfg   = RST_SHORT_HOLD;
    long_cfg    = RST_LONG_HOLD;
    feat_en_cfg = RST_FEAT_EN;
    frame_st    = ST_IDLE;
    held_key    = RST_INVALID_KEY;
    hold_cnt    = '0;
    held_long   = 1'b0;
    feat_reg    = 8'h00;
  endtask

  // Advances the mirror by one request and returns the result it must give.
  function automatic skip_out_t parse_and_hold(input skip_in_t r);
    skip_out_t  o;
    logic [7:0] b;
    logic [5:0] lim;
    int         nxt;
    b = r.rx_byte;
    o = '0;
    o.key_code = inv_key_cfg;
    if (r.req_type == REQ_BYTE) begin
      case (frame_st)
        ST_IDLE: begin
          if (b == SYNC_A) frame_st = ST_KA1;
          else if (b == SYNC_B) frame_st = ST_KEY1;
        end
        ST_KA1: frame_st = (b == SYNC_B) ? ST_KA2 : ST_IDLE;
        ST_KA2: begin
          if (b == KA_ZERO) frame_st = ST_KA3;
          else if (b == KA_FEATURE && feat_en_cfg) frame_st = ST_KAFEAT;
          else frame_st = ST_IDLE;
        end
        ST_KA3: begin
          // plain keep-alive wipes the feature byte
          if (b == KA_ZERO) begin
            feat_reg = 8'h00;
            o.connected = 1'b1;
          end
          frame_st = ST_IDLE;
        end
        ST_KAFEAT: begin
          feat_reg = b;
          o.connected = 1'b1;
          frame_st = ST_IDLE;
        end
        ST_KEY1: frame_st = (b == SYNC_A) ? ST_KEY2 : ST_IDLE;
        ST_KEY2: begin
          if (b == KEY_SHORT) frame_st = ST_KEY3S;
          else if (b == KEY_LONG) frame_st = ST_KEY3L;
          else frame_st = ST_IDLE;
        end
        ST_KEY3S, ST_KEY3L: begin
          // rejected codes still count as a finished packet
          if (b < inv_key_cfg && b != blk_key_cfg) begin
            held_key  = b;
            hold_cnt  = '0;
            held_long = (frame_st == ST_KEY3L);
          end
          o.connected = 1'b1;
          frame_st = ST_IDLE;
        end
        default: frame_st = ST_IDLE;
      endcase
    end else if (held_key != inv_key_cfg) begin
      lim = held_long ? long_cfg : short_cfg;
      nxt = int'(hold_cnt) + 1;
      o.key_valid = 1'b1;
      o.key_code  = held_key;
      if (nxt >= int'(lim)) begin
        held_key  = inv_key_cfg;
        hold_cnt  = '0;
        held_long = 1'b0;
      end else begin
        hold_cnt = nxt[5:0];
      end
    end
    o.viewer_features = feat_reg;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: check results against the oldest prediction, then log any
  // request taken on this edge. A result can never belong to a request taken
  // on the same edge, so check-then-push is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    skip_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: conn=%0d kv=%0d code=%02h feat=%02h",
                     out_data.connected, out_data.key_valid,
                     out_data.key_code, out_data.viewer_features);
        end else begin
          want = due_results.pop_front();
          if (out_data.connected !== want.connected ||
              out_data.key_valid !== want.key_valid ||
              out_data.key_code !== want.key_code ||
              out_data.viewer_features !== want.viewer_features) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: want conn=%0d kv=%0d code=%02h feat=%02h",
                        " got conn=%0d kv=%0d code=%02h feat=%02h"},
                       want.connected, want.key_valid, want.key_code,
                       want.viewer_features, out_data.connected,
                       out_data.key_valid, out_data.key_code,
                       out_data.viewer_features);
          end
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(parse_and_hold(in_data));
    end
  end

  // Result side back-pressure: ~35% stall, none while calm.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 35);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One request; random bubbles ahead of it. Returns on the accepting edge.
  task automatic send_req(input skip_in_t r);
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 35);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    reqs_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    skip_in_t r;
    r.req_type = REQ_BYTE;
    r.rx_byte  = b;
    send_req(r);
  endtask

  // rx_byte is don't-care on polls; randomize it anyway
  task automatic send_poll();
    skip_in_t r;
    r.req_type = REQ_POLL;
    r.rx_byte  = 8'($urandom_range(0, 255));
    send_req(r);
  endtask

  // First n of up to four bytes.
  task automatic send_frame(input int n, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
    if (n > 0) send_byte(b0);
    if (n > 1) send_byte(b1);
    if (n > 2) send_byte(b2);
    if (n > 3) send_byte(b3);
  endtask

  // Stop sending, let every result come back, then a few spare cycles.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called once drained. cfg_we drops after each write
  // before returning, which keeps cfg_we to a single update per step.
  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_IDX_INVALID_KEY: inv_key_cfg = val;
      CFG_IDX_BLOCKED_KEY: blk_key_cfg = val;
      CFG_IDX_SHORT_HOLD:  short_cfg   = val[5:0];
      CFG_IDX_LONG_HOLD:   long_cfg    = val[5:0];
      CFG_IDX_FEAT_EN:     feat_en_cfg = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_all(input logic [7:0] inv, input logic [7:0] blk,
                         input logic [5:0] sh, input logic [5:0] lg, input logic fe);
    cfg_write(CFG_IDX_INVALID_KEY, inv);
    cfg_write(CFG_IDX_BLOCKED_KEY, blk);
    cfg_write(CFG_IDX_SHORT_HOLD, {2'b00, sh});
    cfg_write(CFG_IDX_LONG_HOLD, {2'b00, lg});
    cfg_write(CFG_IDX_FEAT_EN, {7'd0, fe});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Keep-alive and feature framing, plus broken frames.
  task automatic test_keep_alive();
    send_poll();                                              // nothing held yet
    send_frame(4, SYNC_A, SYNC_B, KA_FEATURE, 8'hFF);         // features = FF
    send_frame(4, SYNC_A, SYNC_B, KA_ZERO, KA_ZERO);          // clears features
    send_frame(4, SYNC_A, SYNC_B, KA_ZERO, 8'h80);            // bad last byte
    send_frame(2, SYNC_A, SYNC_A, 8'h00, 8'h00);              // bad 2nd byte, not reparsed
  endtask

  // Key packets: short hold runs out, rejected / blocked codes, long press.
  task automatic test_key_press();
    send_frame(4, SYNC_B, SYNC_A, KEY_SHORT, RST_INVALID_KEY - 8'd1);
    repeat (6) send_poll();                                   // 5 reported, then none
    send_frame(4, SYNC_B, SYNC_A, KEY_LONG, RST_BLOCKED_KEY); // refused, still connected
    send_frame(4, SYNC_B, SYNC_A, KEY_LONG, 8'h00);           // long press, key 0
    send_frame(4, SYNC_B, SYNC_A, KEY_SHORT, 8'hFF);          // out of range, key 0 stays
    send_frame(3, SYNC_B, SYNC_A, 8'h02, 8'h00);              // bad press kind
    send_poll();
  endtask

  // Register corner cases that need writes at specific points.
  task automatic test_cfg_corners();
    // Long hold lowered under a held key: reported at the next poll, then gone.
    drain();
    cfg_write(CFG_IDX_LONG_HOLD, 8'd1);
    repeat (2) send_poll();
    // Feature frames off: 55 AA 05 is a bad third byte.
    drain();
    cfg_write(CFG_IDX_FEAT_EN, 8'd0);
    send_frame(4, SYNC_A, SYNC_B, KA_FEATURE, 8'h77);
    // Enable dropped after 55 AA 05: features byte still taken.
    drain();
    cfg_write(CFG_IDX_FEAT_EN, 8'd1);
    send_frame(3, SYNC_A, SYNC_B, KA_FEATURE, 8'h00);
    drain();
    cfg_write(CFG_IDX_FEAT_EN, 8'd0);
    send_byte(8'h3C);
    // Zero hold: dropped after the first report.
    drain();
    cfg_write(CFG_IDX_SHORT_HOLD, 8'd0);
    send_frame(4, SYNC_B, SYNC_A, KEY_SHORT, 8'h01);
    repeat (2) send_poll();
    // "No key" code moved onto the held key: nothing held until moved back.
    drain();
    cfg_write(CFG_IDX_SHORT_HOLD, 8'd5);
    send_frame(4, SYNC_B, SYNC_A, KEY_SHORT, 8'h07);
    drain();
    cfg_write(CFG_IDX_INVALID_KEY, 8'd7);
    send_poll();
    drain();
    cfg_write(CFG_IDX_INVALID_KEY, RST_INVALID_KEY);
    send_poll();
    drain();
    cfg_all(RST_INVALID_KEY, RST_BLOCKED_KEY, RST_SHORT_HOLD, RST_LONG_HOLD, RST_FEAT_EN);
  endtask

  // Key code that mostly passes the range check, sometimes the blocked one.
  function automatic logic [7:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return blk_key_cfg;
    if (sel < 70 && inv_key_cfg != 8'h00) return 8'($urandom_range(0, inv_key_cfg - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly whole packets with random content and poll bursts; the rest is
  // truncated packets and line noise.
  task automatic random_burst(input int quota);
    int start, kind, n;
    logic [7:0] pkt[4];
    start = reqs_sent;
    while (reqs_sent - start < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 22) begin
        send_frame(4, SYNC_B, SYNC_A, $urandom_range(0, 1) ? KEY_LONG : KEY_SHORT,
                   pick_key());
      end else if (kind < 34) begin
        send_frame(4, SYNC_A, SYNC_B, KA_ZERO, KA_ZERO);
      end else if (kind < 46) begin
        send_frame(4, SYNC_A, SYNC_B, KA_FEATURE, 8'($urandom_range(0, 255)));
      end else if (kind < 74) begin
        repeat ($urandom_range(1, 6)) send_poll();
      end else if (kind < 88) begin
        // cut a packet short and follow it with a random byte
        if ($urandom_range(0, 1)) begin
          pkt[0] = SYNC_A; pkt[1] = SYNC_B;
          pkt[2] = $urandom_range(0, 1) ? KA_ZERO : KA_FEATURE;
        end else begin
          pkt[0] = SYNC_B; pkt[1] = SYNC_A;
          pkt[2] = $urandom_range(0, 1) ? KEY_LONG : KEY_SHORT;
        end
        pkt[3] = 8'($urandom_range(0, 255));
        n = $urandom_range(1, 3);
        pkt[n] = 8'($urandom_range(0, 255));
        send_frame(n + 1, pkt[0], pkt[1], pkt[2], pkt[3]);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Random traffic over several register settings, extremes first.
  task automatic test_random_traffic();
    drain();
    cfg_all(8'd255, 8'd0, 6'd1, 6'd63, 1'b0);
    random_burst(80);
    drain();
    cfg_all(8'd0, 8'd255, 6'd63, 6'd1, 1'b1);
    random_burst(80);
    drain();
    cfg_all(RST_INVALID_KEY, RST_BLOCKED_KEY, RST_SHORT_HOLD, RST_LONG_HOLD, RST_FEAT_EN);
    random_burst(80);
    // back-to-back stretch: no bubbles, no stalls
    drain();
    cfg_all(8'($urandom_range(1, 255)), 8'($urandom_range(0, 40)),
            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    calm = 1'b1;
    random_burst(80);
    drain();
    calm = 1'b0;
    cfg_all(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
            6'($urandom_range(0, 8)), 6'($urandom_range(0, 8)), 1'b1);
    random_burst(80);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mirror_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keep_alive();
    test_key_press();
    test_cfg_corners();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
